FILE: sv/gtl_pkg.sv
// gtl_pkg: shared token record, queue entry type, token kind codes and
// byte classification and keyword table functions for the token lexer.
// Depends on nothing.
`default_nettype none

package gtl_pkg;

	// offsets saturate at the document size limit, never above 16 bits
	localparam int unsigned MAX_DOC_BYTES = 65536;
	localparam logic [15:0] OFFSET_CAP =
		16'((MAX_DOC_BYTES - 1 < 65535) ? MAX_DOC_BYTES - 1 : 65535);

	// keyword prefix length and token count per input byte
	localparam int unsigned KW_MAX_LEN = 12;
	localparam int unsigned NUM_KW     = 28;
	localparam int unsigned MAX_RES    = 5;

	// token kind codes
	localparam logic [5:0] K_IDENT    = 6'd28;
	localparam logic [5:0] K_VAR      = 6'd29;
	localparam logic [5:0] K_DIR      = 6'd30;
	localparam logic [5:0] K_NUM      = 6'd31;
	localparam logic [5:0] K_STR      = 6'd32;
	localparam logic [5:0] K_SYM      = 6'd33;
	localparam logic [5:0] K_PUNCT0   = 6'd34;
	localparam logic [5:0] K_ELLIPSIS = 6'd43;
	localparam logic [5:0] K_UNKNOWN  = 6'd44;
	localparam logic [5:0] K_END      = 6'd45;

	// byte order mark bytes
	localparam logic [7:0] BOM0 = 8'hEF;
	localparam logic [7:0] BOM1 = 8'hBB;
	localparam logic [7:0] BOM2 = 8'hBF;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
	} gtl_token_t;

	// all tokens caused by one byte
	typedef struct packed {
		logic [2:0]                count;
		gtl_token_t [MAX_RES-1:0] tok;
	} gtl_bundle_t;

	function automatic logic [15:0] inc_off(logic [15:0] x);
		return (x < OFFSET_CAP) ? x + 16'd1 : OFFSET_CAP;
	endfunction

	function automatic logic [15:0] inc_len(logic [15:0] x);
		return (x != 16'hFFFF) ? x + 16'd1 : x;
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_numeral(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_name(logic [7:0] b);
		return is_alpha(b) || is_numeral(b);
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	// one-byte symbols not claimed by an earlier rule
	function automatic logic is_symbol(logic [7:0] b);
		return b == "<" || b == ">" || b == "=" || b == "+" || b == "-" ||
			b == "*" || b == "&" || b == "|" || b == "^" || b == "~" ||
			b == "%" || b == "?";
	endfunction

	// punctuator: hit flag in bit 4, index in bits 3:0
	function automatic logic [4:0] punct_of(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		case (b)
			"{": r = {1'b1, 4'd0};
			"}": r = {1'b1, 4'd1};
			"(": r = {1'b1, 4'd2};
			")": r = {1'b1, 4'd3};
			"[": r = {1'b1, 4'd4};
			"]": r = {1'b1, 4'd5};
			":": r = {1'b1, 4'd6};
			",": r = {1'b1, 4'd7};
			"!": r = {1'b1, 4'd8};
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [95:0] kw_word(int unsigned k);
		logic [95:0] w;
		case (k)
			0:  w = "query";
			1:  w = "mutation";
			2:  w = "subscription";
			3:  w = "fragment";
			4:  w = "on";
			5:  w = "true";
			6:  w = "false";
			7:  w = "null";
			8:  w = "type";
			9:  w = "input";
			10: w = "enum";
			11: w = "interface";
			12: w = "union";
			13: w = "directive";
			14: w = "scalar";
			15: w = "extends";
			16: w = "implements";
			17: w = "__typename";
			18: w = "__schema";
			19: w = "__get";
			20: w = "__create";
			21: w = "__update";
			22: w = "__delete";
			23: w = "int";
			24: w = "float";
			25: w = "string";
			26: w = "boolean";
			27: w = "id";
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] kw_len(int unsigned k);
		logic [3:0] l;
		case (k)
			0: l = 4'd5;   1: l = 4'd8;   2: l = 4'd12;  3: l = 4'd8;
			4: l = 4'd2;   5: l = 4'd4;   6: l = 4'd5;   7: l = 4'd4;
			8: l = 4'd4;   9: l = 4'd5;   10: l = 4'd4;  11: l = 4'd9;
			12: l = 4'd5;  13: l = 4'd9;  14: l = 4'd6;  15: l = 4'd7;
			16: l = 4'd10; 17: l = 4'd10; 18: l = 4'd8;  19: l = 4'd5;
			20: l = 4'd8;  21: l = 4'd8;  22: l = 4'd8;  23: l = 4'd3;
			24: l = 4'd5;  25: l = 4'd6;  26: l = 4'd7;  27: l = 4'd2;
			default: l = 4'd0;
		endcase
		return l;
	endfunction

	// character p of keyword k, first character at p = 0
	function automatic logic [7:0] kw_char(int unsigned k, logic [3:0] p);
		logic [95:0] w;
		logic [3:0]  l;
		w = kw_word(k);
		l = kw_len(k);
		if (p < l) begin
			return w[8 * (int'(l) - 1 - int'(p)) +: 8];
		end
		return 8'd0;
	endfunction

endpackage

`default_nettype wire

FILE: sv/gtl_front.sv
// gtl_front: lexer state machine; takes one byte per transaction and
// builds the bundle of tokens that byte causes.
// Depends on gtl_pkg.
`default_nettype none

module gtl_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          text_byte,
	input  wire                 doc_last,
	input  wire                 take,
	output gtl_pkg::gtl_bundle_t bundle,
	output logic                has_tokens
);
	import gtl_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_DOTS, M_DOLLAR, M_AT,
		M_VAR, M_DIR, M_IDENT, M_NUM, M_STR
	} mode_t;

	typedef struct packed {
		logic       a_en;
		gtl_token_t a;
		logic       b_en;
		gtl_token_t b;
	} flush_t;

	mode_t             mode_q, mode_n;
	logic [15:0]       start_q, start_n;
	logic [15:0]       run_q, run_n;
	logic [15:0]       offset_q, offset_n;
	logic [NUM_KW-1:0] match_q, match_n;
	logic              seen_q, seen_n;
	logic              squote_q, squote_n;
	logic              esc_q, esc_n;
	logic [1:0]        dots_q, dots_n;
	logic [1:0]        bom_q, bom_n;
	logic              star_q, star_n;
	logic              docstart_q, docstart_n;

	// first keyword whose letters all matched and whose length is the run
	function automatic logic [5:0] kw_kind(logic [NUM_KW-1:0] m, logic [15:0] rl);
		logic [5:0] r;
		r = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (m[k] && rl == 16'(kw_len(k))) r = 6'(k);
		end
		return r;
	endfunction

	// token(s) left pending by a mode when it ends
	function automatic flush_t flush_of(mode_t m, logic [1:0] dots, logic [15:0] st,
			logic [15:0] rl, logic [5:0] kwk);
		flush_t f;
		f = '0;
		f.a.start = st;
		f.a.len   = rl;
		f.b       = '{kind: K_UNKNOWN, start: inc_off(st), len: 16'd1};
		case (m)
			M_SLASH, M_DOLLAR, M_AT: begin
				f.a_en  = 1'b1;
				f.a     = '{kind: K_SYM, start: st, len: 16'd1};
			end
			M_DOTS: begin
				f.a_en  = dots != 2'd0;
				f.a     = '{kind: K_UNKNOWN, start: st, len: 16'd1};
				f.b_en  = dots >= 2'd2;
			end
			M_VAR: begin
				f.a_en = 1'b1; f.a.kind = K_VAR;
			end
			M_DIR: begin
				f.a_en = 1'b1; f.a.kind = K_DIR;
			end
			M_IDENT: begin
				f.a_en = 1'b1; f.a.kind = kwk;
			end
			M_NUM: begin
				f.a_en = 1'b1; f.a.kind = K_NUM;
			end
			M_STR: begin
				f.a_en = 1'b1; f.a.kind = K_STR;
			end
			default: f.a_en = 1'b0;
		endcase
		return f;
	endfunction

	logic                       consumed, relex, idle;
	logic [7:0]                 c_en;
	gtl_token_t [7:0]           c_tok;
	flush_t                     fl_step, fl_last;
	logic [4:0]                 pc;
	logic [2:0]                 cnt;

	// next state and candidate tokens in emission order
	always_comb begin
		mode_n     = mode_q;
		start_n    = start_q;
		run_n      = run_q;
		match_n    = match_q;
		seen_n     = seen_q;
		squote_n   = squote_q;
		esc_n      = esc_q;
		dots_n     = dots_q;
		bom_n      = bom_q;
		star_n     = star_q;
		docstart_n = docstart_q;
		consumed   = 1'b0;
		relex      = 1'b0;
		idle       = 1'b0;
		c_en       = '0;
		c_tok      = '0;
		pc         = punct_of(text_byte);
		c_tok[0]   = '{kind: K_UNKNOWN, start: 16'd0, len: 16'd1};
		c_tok[1]   = '{kind: K_UNKNOWN, start: inc_off(16'd0), len: 16'd1};
		c_tok[4]   = '{kind: K_UNKNOWN, start: offset_q, len: 16'd1};

		// byte order mark at document start
		if (docstart_q) begin
			docstart_n = 1'b0;
			if (text_byte == BOM0) begin
				bom_n = 2'd1; consumed = 1'b1;
			end
		end else if (bom_q == 2'd1) begin
			if (text_byte == BOM1) begin
				bom_n = 2'd2; consumed = 1'b1;
			end else begin
				c_en[0] = 1'b1; bom_n = 2'd0;
			end
		end else if (bom_q >= 2'd2) begin
			consumed = 1'b1;
			if (text_byte != BOM2) begin
				consumed = 1'b0; c_en[0] = 1'b1; c_en[1] = 1'b1;
			end
			bom_n = 2'd0;
		end

		// mode step
		if (!consumed) begin
			case (mode_q)
				M_SLASH: begin
					if (text_byte == "/") mode_n = M_LINE;
					else if (text_byte == "*") begin
						mode_n = M_BLOCK; star_n = 1'b0;
					end else relex = 1'b1;
				end
				M_LINE: begin
					if (text_byte == 8'h0A) mode_n = M_IDLE;
				end
				M_BLOCK: begin
					if (star_q && text_byte == "/") begin
						mode_n = M_IDLE; star_n = 1'b0;
					end else star_n = text_byte == "*";
				end
				M_DOTS: begin
					if (text_byte == ".") begin
						if (dots_q >= 2'd2) begin
							c_en[4]  = 1'b1;
							c_tok[4] = '{kind: K_ELLIPSIS, start: start_q, len: 16'd3};
							mode_n   = M_IDLE;
							dots_n   = 2'd0;
						end else dots_n = dots_q + 2'd1;
					end else relex = 1'b1;
				end
				M_DOLLAR, M_AT: begin
					if (is_name(text_byte)) begin
						mode_n = (mode_q == M_DOLLAR) ? M_VAR : M_DIR;
						run_n  = inc_len(run_q);
					end else relex = 1'b1;
				end
				M_VAR, M_DIR: begin
					if (is_name(text_byte)) run_n = inc_len(run_q);
					else relex = 1'b1;
				end
				M_IDENT: begin
					if (is_name(text_byte)) begin
						if (run_q < 16'(KW_MAX_LEN)) begin
							for (int k = 0; k < NUM_KW; k++) begin
								if (run_q[3:0] < kw_len(k))
									match_n[k] = match_q[k] &&
										text_byte == kw_char(k, run_q[3:0]);
							end
						end
						run_n = inc_len(run_q);
					end else relex = 1'b1;
				end
				M_NUM: begin
					if (is_numeral(text_byte)) run_n = inc_len(run_q);
					else if (text_byte == "." && !seen_q) begin
						seen_n = 1'b1; run_n = inc_len(run_q);
					end else relex = 1'b1;
				end
				M_STR: begin
					run_n = inc_len(run_q);
					if (esc_q) esc_n = 1'b0;
					else if (text_byte == "\\") esc_n = 1'b1;
					else if (text_byte == (squote_q ? "'" : "\"")) begin
						c_en[4]  = 1'b1;
						c_tok[4] = '{kind: K_STR, start: start_q, len: inc_len(run_q)};
						mode_n   = M_IDLE;
					end
				end
				default: idle = 1'b1;
			endcase

			// pending token ended by this byte, which is then lexed afresh
			fl_step = flush_of(mode_q, dots_q, start_q, run_q, kw_kind(match_q, run_q));
			if (relex) begin
				c_en[2]  = fl_step.a_en;
				c_tok[2] = fl_step.a;
				c_en[3]  = fl_step.b_en;
				c_tok[3] = fl_step.b;
				dots_n   = 2'd0;
				seen_n   = 1'b0;
				esc_n    = 1'b0;
				star_n   = 1'b0;
				idle     = 1'b1;
			end

			// byte between tokens
			if (idle) begin
				mode_n = M_IDLE;
				if (is_space(text_byte)) begin
					mode_n = M_IDLE;
				end else if (text_byte == "#") begin
					mode_n = M_LINE;
				end else if (text_byte == "/") begin
					mode_n = M_SLASH; start_n = offset_q; run_n = 16'd1;
				end else if (text_byte == ".") begin
					mode_n = M_DOTS; start_n = offset_q; run_n = 16'd1; dots_n = 2'd1;
				end else if (text_byte == "$") begin
					mode_n = M_DOLLAR; start_n = offset_q; run_n = 16'd1;
				end else if (text_byte == "@") begin
					mode_n = M_AT; start_n = offset_q; run_n = 16'd1;
				end else if (pc[4]) begin
					c_en[4]       = 1'b1;
					c_tok[4].kind = K_PUNCT0 + 6'(pc[3:0]);
				end else if (is_symbol(text_byte)) begin
					c_en[4]       = 1'b1;
					c_tok[4].kind = K_SYM;
				end else if (is_alpha(text_byte)) begin
					mode_n = M_IDENT; start_n = offset_q; run_n = 16'd1;
					for (int k = 0; k < NUM_KW; k++)
						match_n[k] = text_byte == kw_char(k, 4'd0);
				end else if (is_numeral(text_byte)) begin
					mode_n = M_NUM; start_n = offset_q; run_n = 16'd1; seen_n = 1'b0;
				end else if (text_byte == "\"" || text_byte == "'") begin
					mode_n   = M_STR; start_n = offset_q; run_n = 16'd1;
					squote_n = text_byte == "'";
					esc_n    = 1'b0;
				end else begin
					c_en[4] = 1'b1;
				end
			end
		end else begin
			fl_step = '0;
		end

		offset_n = inc_off(offset_q);

		// end of document: flush everything and return to reset state
		fl_last  = flush_of(mode_n, dots_n, start_n, run_n, kw_kind(match_n, run_n));
		c_tok[5] = fl_last.a;
		c_tok[6] = fl_last.b;
		c_tok[7] = '{kind: K_END, start: offset_n, len: 16'd0};
		if (doc_last) begin
			if (bom_n != 2'd0) c_en[0] = 1'b1;
			if (bom_n >= 2'd2) c_en[1] = 1'b1;
			c_en[5]    = fl_last.a_en;
			c_en[6]    = fl_last.b_en;
			c_en[7]    = 1'b1;
			mode_n     = M_IDLE;
			start_n    = '0;
			run_n      = '0;
			offset_n   = '0;
			seen_n     = 1'b0;
			squote_n   = 1'b0;
			esc_n      = 1'b0;
			dots_n     = 2'd0;
			bom_n      = 2'd0;
			star_n     = 1'b0;
			docstart_n = 1'b1;
		end

		// pack enabled candidates in order, at most five
		bundle = '0;
		cnt    = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (c_en[i] && cnt < 3'(MAX_RES)) begin
				bundle.tok[cnt] = c_tok[i];
				cnt = cnt + 3'd1;
			end
		end
		bundle.count = cnt;
		has_tokens   = cnt != 3'd0;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			start_q    <= '0;
			run_q      <= '0;
			offset_q   <= '0;
			match_q    <= '0;
			seen_q     <= 1'b0;
			squote_q   <= 1'b0;
			esc_q      <= 1'b0;
			dots_q     <= 2'd0;
			bom_q      <= 2'd0;
			star_q     <= 1'b0;
			docstart_q <= 1'b1;
		end else if (take) begin
			mode_q     <= mode_n;
			start_q    <= start_n;
			run_q      <= run_n;
			offset_q   <= offset_n;
			match_q    <= match_n;
			seen_q     <= seen_n;
			squote_q   <= squote_n;
			esc_q      <= esc_n;
			dots_q     <= dots_n;
			bom_q      <= bom_n;
			star_q     <= star_n;
			docstart_q <= docstart_n;
		end
	end

endmodule

`default_nettype wire

FILE: sv/gtl_queue.sv
// gtl_queue: small register queue of token bundles between the lexer
// front and the token serializer.
// Depends on gtl_pkg.
`default_nettype none

module gtl_queue #(
	parameter int DEPTH = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire gtl_pkg::gtl_bundle_t push_data,
	input  wire                  pop,
	output gtl_pkg::gtl_bundle_t head,
	output logic                 full,
	output logic                 empty
);
	import gtl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	gtl_bundle_t       entry_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

FILE: sv/gtl_back.sv
// gtl_back: walks the head bundle one token per transaction and
// releases the bundle after its last token.
// Depends on gtl_pkg.
`default_nettype none

module gtl_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire gtl_pkg::gtl_bundle_t head,
	input  wire                  head_valid,
	input  wire                  token_stall,
	output logic                 token_valid,
	output logic [5:0]           token_kind,
	output logic [15:0]          token_start,
	output logic [15:0]          token_length,
	output logic                 last_of_run,
	output logic                 pop
);
	import gtl_pkg::*;

	logic [2:0] idx_q;
	gtl_token_t cur;

	// current token of the head bundle
	assign cur          = head.tok[idx_q];
	assign token_valid  = head_valid;
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.len;
	assign last_of_run  = idx_q == head.count - 3'd1;
	assign pop          = token_valid && !token_stall && last_of_run;

	// slot index within the bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (token_valid && !token_stall) begin
			idx_q <= last_of_run ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

FILE: sv/graphql_token_lexer.sv
// graphql_token_lexer: byte-serial lexer that emits (kind, start, length) tokens.
// Latency: with the queue empty, tokens of a byte are offered the cycle after
// that byte's transaction.
// Throughput: one byte per cycle while the queue is not full (text_stall); a byte's
// tokens leave one at a time, and the bundle queue (QUEUE_DEPTH bundles) absorbs bursts.
// Reset: asynchronous, all lexer and queue control state cleared at once.
// Depends on gtl_pkg, gtl_front, gtl_queue, gtl_back.
`default_nettype none

module graphql_token_lexer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         text_valid,
	output logic        text_stall,
	input  wire  [7:0]  text_byte,
	input  wire         doc_last,
	output logic        token_valid,
	input  wire         token_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	import gtl_pkg::*;

	gtl_bundle_t bundle, head;
	logic        has_tokens, full, empty, take, pop;

	assign text_stall = full;
	assign take       = text_valid && !text_stall;

	gtl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.doc_last   (doc_last),
		.take       (take),
		.bundle     (bundle),
		.has_tokens (has_tokens)
	);

	gtl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && has_tokens),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	gtl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.token_stall  (token_stall),
		.token_valid  (token_valid),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.pop          (pop)
	);

	// document end always closes the run of its byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == K_END |-> last_of_run)
		else $error("document end not last token of its byte");

	// only the document end marker has zero length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_length != 16'd0 || token_kind == K_END)
		else $error("zero length token");

	// punctuators are single bytes
	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind >= K_PUNCT0 && token_kind < K_ELLIPSIS
		|-> token_length == 16'd1)
		else $error("punctuator length not one");

endmodule

`default_nettype wire
